/* sv/lkc_pkg.sv */
package lkc_pkg;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  // per-cycle broadcast from the controller to the row of cells
  typedef struct packed {
    logic        promote;   // move matched entry to front
    logic        commit;    // insert new entry at front
  } cell_ctl_t;

endpackage

/* sv/lkc_cell.sv */
// one slot of the cache: tag, valid and recency rank; age shifts are local
module lkc_cell #(
  parameter int RW = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  input  lkc_pkg::cell_ctl_t ctl,
  input  logic [31:0]       key,
  input  logic [RW-1:0]     ref_rank,
  input  logic              sel,
  output logic              match,
  output logic              valid,
  output logic [RW-1:0]     rank
);
  logic          valid_r, valid_nxt;
  logic [31:0]   tag_r;
  logic [RW-1:0] rank_r, rank_nxt;

  assign match = valid_r && (tag_r == key);
  assign valid = valid_r;
  assign rank  = rank_r;

  always_comb begin
    valid_nxt = valid_r;
    rank_nxt  = rank_r;
    if (ctl.promote) begin
      if (sel) rank_nxt = '0;
      else if (valid_r && rank_r < ref_rank) rank_nxt = rank_r + 1'b1;
    end else if (ctl.commit) begin
      if (sel) begin
        valid_nxt = 1'b1;
        rank_nxt  = '0;
      end else if (valid_r) begin
        rank_nxt = rank_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    rank_r <= rank_nxt;
    if (ctl.commit && sel) tag_r <= key;
  end
endmodule

/* sv/lkc_sel.sv */
// registered scan selector: walks the cells one per cycle and keeps the best
module lkc_sel #(
  parameter int N  = 128,
  parameter int IW = 7,
  parameter int RW = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          mode_old,  // 1: oldest valid, 0: lowest-rank match
  input  logic [N-1:0]  match,
  input  logic [N-1:0]  valid,
  input  logic [RW-1:0] ranks [N],
  output logic          done,
  output logic          found,
  output logic [IW-1:0] idx,
  output logic [RW-1:0] best_rank
);
  logic          busy_r, busy_nxt;
  logic [IW-1:0] ptr_r, ptr_nxt;
  logic          found_r, found_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [RW-1:0] best_r, best_nxt;
  logic          cand, better;

  assign cand   = mode_old ? valid[ptr_r] : match[ptr_r];
  assign better = !found_r || (mode_old ? (ranks[ptr_r] > best_r)
                                        : (ranks[ptr_r] < best_r));
  assign done      = busy_r && (ptr_r == IW'(N - 1));
  assign found     = found_nxt;
  assign idx       = idx_nxt;
  assign best_rank = best_nxt;

  always_comb begin
    busy_nxt  = busy_r;
    ptr_nxt   = ptr_r;
    found_nxt = found_r;
    idx_nxt   = idx_r;
    best_nxt  = best_r;
    if (start) begin
      busy_nxt  = 1'b1;
      ptr_nxt   = '0;
      found_nxt = 1'b0;
      idx_nxt   = '0;
      best_nxt  = '0;
    end else if (busy_r) begin
      if (cand && better) begin
        found_nxt = 1'b1;
        idx_nxt   = ptr_r;
        best_nxt  = ranks[ptr_r];
      end
      if (done) busy_nxt = 1'b0;
      else ptr_nxt = ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      found_r <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      found_r <= found_nxt;
    end
    ptr_r  <= ptr_nxt;
    idx_r  <= idx_nxt;
    best_r <= best_nxt;
  end
endmodule

/* sv/lru_key_cache.sv */
// channel | ports                                           | direction
// in      | in_valid in_ready in_cmd in_key_id in_byte      | request in
// out     | out_valid out_ready out_hit out_byte            | result out
//         | out_is_last out_evicted                         |
// one request at a time; a lookup scans ENTRIES cells one per cycle, then a
// miss loads its result. a hit adds an update step, then per byte a memory
// read and an output load. a final insert byte goes through commit, copy
// and ack, preceded by a scan of all cells for the oldest slot when full;
// other insert bytes are only staged. out_ready low stalls the output and
// in_ready waits for the last result to leave; reset is synchronous.
module lru_key_cache #(
  parameter int ENTRIES   = 128,
  parameter int KEY_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [31:0] in_key_id,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_hit,
  output logic [7:0]  out_byte,
  output logic        out_is_last,
  output logic        out_evicted
);
  localparam int IW = $clog2(ENTRIES);
  localparam int RW = $clog2(ENTRIES);
  localparam int BW = $clog2(KEY_BYTES + 1);
  localparam int BI = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam int AW = $clog2(ENTRIES * KEY_BYTES);
  localparam int CW = $clog2(ENTRIES + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_UPD  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;
  localparam logic [2:0] S_COPY = 3'd5;
  localparam logic [2:0] S_ACK  = 3'd6;

  logic [2:0]    state_r, state_nxt;
  logic          is_ins_r;
  logic [31:0]   key_r;
  logic [IW-1:0] slot_r;
  logic [RW-1:0] srank_r;
  logic          ev_r;
  logic [BW-1:0] cnt_r;
  logic [CW-1:0] count_r;
  logic [BW-1:0] sidx_r;
  logic [31:0]   sid_r;
  logic [7:0]    stage_r [KEY_BYTES];
  logic [7:0]    mem [ENTRIES * KEY_BYTES];
  logic [7:0]    rd_r;
  logic          ov_r, ohit_r, olast_r, oev_r;
  logic [7:0]    obyte_r;

  lkc_pkg::cell_ctl_t ctl;
  logic [ENTRIES-1:0] match, valid, sel;
  logic [RW-1:0]      ranks [ENTRIES];
  logic [IW-1:0]      free_idx;
  logic               free_ok;
  logic sel_start, sel_done, sel_found;
  logic [IW-1:0] sel_idx;
  logic [RW-1:0] sel_rank;
  logic take, last_byte, load_out;
  logic [BI-1:0] sbi;
  logic [AW-1:0] waddr, raddr;

  assign in_ready = (state_r == S_IDLE) && !ov_r;
  assign take = in_valid && in_ready;
  assign sbi  = (sidx_r >= BW'(KEY_BYTES)) ? '0 : sidx_r[BI-1:0];
  assign last_byte = (32'(sbi) == 32'(KEY_BYTES - 1));
  assign load_out = ((state_r == S_OUT) || (state_r == S_ACK)) && (!ov_r || out_ready);

  genvar g;
  for (g = 0; g < ENTRIES; g++) begin : g_cell
    assign sel[g] = (slot_r == IW'(g));
    lkc_cell #(.RW(RW)) u_cell (
      .clk(clk), .rst_n(rst_n), .ctl(ctl), .key(ctl.commit ? sid_r : key_r),
      .ref_rank(srank_r), .sel(sel[g]), .match(match[g]), .valid(valid[g]),
      .rank(ranks[g])
    );
  end

  // free slot: lowest invalid cell
  always_comb begin
    free_idx = '0;
    free_ok  = 1'b0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_idx = IW'(i);
        free_ok  = 1'b1;
      end
    end
  end

  lkc_sel #(.N(ENTRIES), .IW(IW), .RW(RW)) u_sel (
    .clk(clk), .rst_n(rst_n), .start(sel_start), .mode_old(is_ins_r),
    .match(match), .valid(valid), .ranks(ranks), .done(sel_done),
    .found(sel_found), .idx(sel_idx), .best_rank(sel_rank)
  );

  assign waddr = AW'(32'(slot_r) * KEY_BYTES + 32'(cnt_r));
  assign raddr = waddr;

  always_comb begin
    ctl = '0;
    ctl.promote = (state_r == S_UPD) && !is_ins_r;
    ctl.commit  = (state_r == S_UPD) && is_ins_r;
  end

  assign sel_start = 1'b0 | ((state_r == S_IDLE) && take &&
                     (in_cmd == lkc_pkg::CMD_LOOKUP ||
                      (last_byte && count_r == CW'(ENTRIES))));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (take) begin
        if (in_cmd == lkc_pkg::CMD_LOOKUP) state_nxt = S_SCAN;
        else if (last_byte) state_nxt = (count_r == CW'(ENTRIES)) ? S_SCAN : S_UPD;
      end
      S_SCAN: if (sel_done) state_nxt = (is_ins_r || sel_found) ? S_UPD : S_ACK;
      S_UPD:  state_nxt = is_ins_r ? S_COPY : S_RD;
      S_RD:   state_nxt = S_OUT;
      S_OUT:  if (!ov_r || out_ready) begin
        state_nxt = (cnt_r == BW'(KEY_BYTES - 1)) ? S_IDLE : S_RD;
      end
      S_COPY: if (cnt_r == BW'(KEY_BYTES - 1)) state_nxt = S_ACK;
      S_ACK:  if (!ov_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == S_COPY) mem[waddr] <= stage_r[cnt_r[BI-1:0]];
    rd_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      sidx_r  <= '0;
      ov_r    <= 1'b0;
      sid_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (load_out) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (take) begin
          is_ins_r <= in_cmd;
          key_r    <= in_key_id;
          cnt_r    <= '0;
          ev_r     <= 1'b0;
          if (in_cmd == lkc_pkg::CMD_INSERT) begin
            if (sbi == '0) sid_r <= in_key_id;
            stage_r[sbi] <= in_byte;
            sidx_r <= last_byte ? '0 : BW'(sbi) + 1'b1;
            if (last_byte && count_r != CW'(ENTRIES)) begin
              slot_r <= free_idx;
              count_r <= count_r + 1'b1;
            end
          end
        end
        S_SCAN: if (sel_done) begin
          slot_r  <= sel_idx;
          srank_r <= sel_rank;
          if (is_ins_r) ev_r <= 1'b1;
        end
        S_UPD: ;
        S_RD:  ;
        S_OUT: if (!ov_r || out_ready) begin
          ohit_r  <= 1'b1;
          obyte_r <= rd_r;
          olast_r <= (cnt_r == BW'(KEY_BYTES - 1));
          oev_r   <= 1'b0;
          cnt_r   <= cnt_r + 1'b1;
        end
        S_COPY: cnt_r <= cnt_r + 1'b1;
        S_ACK: if (!ov_r || out_ready) begin
          ohit_r  <= 1'b0;
          obyte_r <= '0;
          olast_r <= 1'b1;
          oev_r   <= ev_r;
        end
        default: ;
      endcase
    end
  end

  assign out_valid   = ov_r;
  assign out_hit     = ohit_r;
  assign out_byte    = obyte_r;
  assign out_is_last = olast_r;
  assign out_evicted = oev_r;

  ap_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready) else $error("request taken while busy");
  ap_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(ENTRIES)) else $error("entry count overflow");
  ap_miss_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> out_is_last) else $error("miss or ack without last");
  ap_free_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (take && in_cmd && last_byte && count_r != CW'(ENTRIES)) |-> free_ok)
    else $error("no free slot below full count");
endmodule

/* test/tb.sv */
`timescale 1ns / 100ps

module tb;

  localparam int ENTRIES   = 128;
  localparam int KEY_BYTES = 32;

  typedef struct packed {
    logic        cmd;
    logic [31:0] id;
    logic [7:0]  data;
  } request_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] data;
    logic       last;
    logic       ev;
  } result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_cmd = lkc_pkg::CMD_LOOKUP;
  logic [31:0] in_key_id = '0;
  logic [7:0]  in_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_hit;
  logic [7:0]  out_byte;
  logic        out_is_last;
  logic        out_evicted;

  lru_key_cache #(.ENTRIES(ENTRIES), .KEY_BYTES(KEY_BYTES)) dut (.*);

  always #10 clk = ~clk;

  // predictor state
  logic [31:0] slot_id [ENTRIES];
  logic        slot_used [ENTRIES];
  int          slot_rank [ENTRIES];
  logic [7:0]  slot_secret [ENTRIES][KEY_BYTES];
  int          used_count;
  logic [7:0]  stage_secret [KEY_BYTES];
  logic [31:0] stage_id;
  int          stage_pos;

  request_t pending_reqs[$];
  result_t  expected_results[$];
  logic [31:0] known_ids[$];
  int errors, n_sent, n_got, n_hits, n_evicts;
  bit quiet;

  task automatic report(input string what, input result_t got, input result_t want);
    errors++;
    $display("mismatch %s: got hit=%0b byte=%02h last=%0b ev=%0b want %0b %02h %0b %0b",
             what, got.hit, got.data, got.last, got.ev, want.hit, want.data, want.last,
             want.ev);
  endtask

  task automatic predict_lookup(input logic [31:0] id);
    int found, r;
    found = -1;
    for (int s = 0; s < ENTRIES; s++)
      if (slot_used[s] && slot_id[s] == id && (found < 0 || slot_rank[s] < slot_rank[found]))
        found = s;
    if (found < 0) begin
      expected_results.push_back('{1'b0, 8'h00, 1'b1, 1'b0});
      return;
    end
    r = slot_rank[found];
    for (int s = 0; s < ENTRIES; s++)
      if (slot_used[s] && slot_rank[s] < r) slot_rank[s]++;
    slot_rank[found] = 0;
    for (int i = 0; i < KEY_BYTES; i++)
      expected_results.push_back('{1'b1, slot_secret[found][i], i == KEY_BYTES - 1, 1'b0});
  endtask

  task automatic predict_commit();
    int slot;
    logic ev;
    slot = -1;
    ev = 1'b0;
    if (used_count < ENTRIES)
      for (int s = 0; s < ENTRIES; s++)
        if (!slot_used[s]) begin
          slot = s;
          break;
        end
    if (slot < 0) begin
      for (int s = 0; s < ENTRIES; s++)
        if (slot_used[s] && (slot < 0 || slot_rank[s] > slot_rank[slot])) slot = s;
      if (slot < 0) slot = 0;
      slot_used[slot] = 1'b0;
      ev = 1'b1;
    end else begin
      used_count++;
    end
    for (int s = 0; s < ENTRIES; s++)
      if (slot_used[s]) slot_rank[s]++;
    slot_used[slot] = 1'b1;
    slot_id[slot] = stage_id;
    slot_rank[slot] = 0;
    for (int i = 0; i < KEY_BYTES; i++) slot_secret[slot][i] = stage_secret[i];
    expected_results.push_back('{1'b0, 8'h00, 1'b1, ev});
  endtask

  task automatic predict(input request_t rq);
    if (rq.cmd == lkc_pkg::CMD_LOOKUP) begin
      predict_lookup(rq.id);
      return;
    end
    if (stage_pos == 0) stage_id = rq.id;
    stage_secret[stage_pos] = rq.data;
    stage_pos++;
    if (stage_pos == KEY_BYTES) begin
      stage_pos = 0;
      predict_commit();
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict('{in_cmd, in_key_id, in_byte});
        n_sent++;
      end
      if ((!in_valid || in_ready) && pending_reqs.size() > 0 &&
          (quiet || $urandom_range(99) >= 11)) begin
        request_t rq;
        rq = pending_reqs.pop_front();
        in_valid <= 1'b1;
        in_cmd <= rq.cmd;
        in_key_id <= rq.id;
        in_byte <= rq.data;
      end else if (in_valid && in_ready) begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        result_t got, want;
        got = '{out_hit, out_byte, out_is_last, out_evicted};
        n_got++;
        if (expected_results.size() == 0) begin
          report("unexpected", got, got);
        end else begin
          want = expected_results.pop_front();
          if (got.hit && got.last) n_hits++;
          if (got.ev) n_evicts++;
          if (got.hit != want.hit) report("hit", got, want);
          if (got.data != want.data) report("out_byte", got, want);
          if (got.last != want.last) report("is_last", got, want);
          if (got.ev != want.ev) report("evicted", got, want);
        end
      end
      out_ready <= quiet || $urandom_range(99) >= 11;
    end
  end

  task automatic add_insert(input logic [31:0] id, input logic [7:0] fill, input bit rnd);
    for (int i = 0; i < KEY_BYTES; i++) begin
      logic [7:0] b;
      b = rnd ? 8'($urandom) : fill ^ 8'(i);
      // later byte items carry junk ids, which the block ignores
      pending_reqs.push_back('{lkc_pkg::CMD_INSERT, (i == 0) ? id : $urandom, b});
    end
    known_ids.push_back(id);
  endtask

  function automatic logic [31:0] pick_id();
    if (known_ids.size() > 0 && $urandom_range(3) != 0)
      return known_ids[$urandom_range(known_ids.size() - 1)];
    return $urandom_range(3) == 0 ? $urandom : 32'($urandom_range(15));
  endfunction

  initial begin
    int n;
    for (int s = 0; s < ENTRIES; s++) slot_used[s] = 1'b0;
    used_count = 0;
    stage_pos = 0;
    stage_id = '0;
    quiet = 1'b0;
    // directed: empty cache, extreme ids and bytes, duplicates
    pending_reqs.push_back('{lkc_pkg::CMD_LOOKUP, 32'h0, 8'hff});
    pending_reqs.push_back('{lkc_pkg::CMD_LOOKUP, 32'hffff_ffff, 8'h00});
    add_insert(32'hffff_ffff, 8'hff, 0);
    add_insert(32'h0, 8'h00, 0);
    pending_reqs.push_back('{lkc_pkg::CMD_LOOKUP, 32'hffff_ffff, 8'h00});
    pending_reqs.push_back('{lkc_pkg::CMD_LOOKUP, 32'h0, 8'h00});
    add_insert(32'h0, 8'h5a, 0);
    pending_reqs.push_back('{lkc_pkg::CMD_LOOKUP, 32'h0, 8'h00});
    // lookup in the middle of a pending insert
    for (int i = 0; i < KEY_BYTES; i++) begin
      pending_reqs.push_back('{lkc_pkg::CMD_INSERT, 32'ha5a5_5a5a, 8'(i * 7)});
      if (i == 10) pending_reqs.push_back('{lkc_pkg::CMD_LOOKUP, 32'hffff_ffff, 8'h00});
    end
    pending_reqs.push_back('{lkc_pkg::CMD_LOOKUP, 32'ha5a5_5a5a, 8'h00});
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    // random traffic up to the request budget
    n = 0;
    while (n_sent + pending_reqs.size() < 500) begin
      if ($urandom_range(99) < 70) begin
        pending_reqs.push_back('{lkc_pkg::CMD_LOOKUP, pick_id(), 8'($urandom)});
      end else if ($urandom_range(9) == 0) begin
        add_insert(pick_id(), 8'h00, 1);
      end else begin
        add_insert($urandom_range(3) == 0 ? $urandom : 32'($urandom_range(15)), 8'h00, 1);
      end
      if (n == 8) begin
        wait (pending_reqs.size() == 0);
        quiet = 1'b1;
      end
      if (n == 18) begin
        wait (pending_reqs.size() == 0);
        quiet = 1'b0;
      end
      n++;
    end
    wait (pending_reqs.size() == 0 && !in_valid);
    wait (expected_results.size() == 0);
    repeat (2 * ENTRIES + 4 * KEY_BYTES) @(posedge clk);
    $display("sent %0d requests, checked %0d results: %0d hits, %0d evictions",
             n_sent, n_got, n_hits, n_evicts);
    if (errors == 0 && expected_results.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
